// ===== src/ccm_pkg.sv =====
`timescale 1ns / 1ps
package ccm_pkg;

  localparam int unsigned SHARE_W = 16;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned ACC_W   = 28;
  localparam int unsigned DIV_W   = 32;

  // Counter widths below are sized for these limits.
  localparam int unsigned MAX_ROWS    = 4096;
  localparam int unsigned MAX_COLUMNS = 4096;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  localparam logic [1:0] REG_CHANNEL = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_COLUMNS = 2'd2;

  // Pixel as classified by the front end, queued for the share divider.
  typedef struct packed {
    logic [LEVEL_W-1:0] chosen;
    logic [SUM_W-1:0]   total;
    logic               frame_start;
  } pix_t;

  // Divider start/done handshake between back end and divider.
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   numer;
    logic [DIV_W-1:0]   denom;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quot;
  } div_rsp_t;

endpackage

// ===== src/ccm_front.sv =====
`timescale 1ns / 1ps
module ccm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          red,
  input  logic [15:0]          green,
  input  logic [15:0]          blue,
  input  logic                 frame_start,
  input  logic [1:0]           channel_select,
  output logic                 q_valid,
  input  logic                 q_ready,
  output ccm_pkg::pix_t        q_data
);
  import ccm_pkg::*;

  localparam int unsigned DEPTH = 2;

  pix_t          mem_r [DEPTH];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  pix_t          pix;
  logic          push, pop;

  always_comb begin
    unique case (channel_select)
      CHAN_GREEN: pix.chosen = green;
      CHAN_BLUE:  pix.chosen = blue;
      default:    pix.chosen = red;
    endcase
    pix.total       = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
    pix.frame_start = frame_start;
  end

  assign in_ready = (cnt_r != 2'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];
  assign wp_nxt   = push ? ~wp_r : wp_r;
  assign rp_nxt   = pop ? ~rp_r : rp_r;
  assign cnt_nxt  = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= pix;
  end

endmodule

// ===== src/ccm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module ccm_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ccm_pkg::div_req_t    req,
  output ccm_pkg::div_rsp_t    rsp
);
  import ccm_pkg::*;

  logic [DIV_W-1:0]   q_r, q_nxt, d_r, d_nxt;
  logic [DIV_W:0]     rem_r, rem_nxt, trial;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DIV_W-1:0], q_r[DIV_W-1]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt    = req.numer;
      d_nxt    = req.denom;
      rem_nxt  = '0;
      cnt_nxt  = 6'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DIV_W]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DIV_W-1:0], q_r[DIV_W-1]};
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// ===== src/ccm_back.sv =====
`timescale 1ns / 1ps
module ccm_back #(
  parameter int unsigned REPLICATES  = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  ccm_pkg::pix_t        q_data,
  input  logic [12:0]          rows_per_column,
  input  logic [12:0]          columns_per_frame,
  output ccm_pkg::div_req_t    div_req,
  input  ccm_pkg::div_rsp_t    div_rsp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [11:0]          column_index,
  output logic [1:0]           replicate_index,
  output logic [15:0]          replicate_mean,
  output logic [15:0]          group_mean,
  output logic                 group_valid
);
  import ccm_pkg::*;

  // Group mean by reciprocal multiply: exact floor for sums below 2^18.
  localparam int unsigned GRP_SHIFT = 19;
  localparam logic [19:0] GRP_RECIP = 20'((2 ** GRP_SHIFT + REPLICATES - 1) / REPLICATES);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SHARE = 5'b00010,
    ST_MEAN  = 5'b00100,
    ST_GROUP = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t            st_r, st_nxt;
  logic [11:0]       row_r, row_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [1:0]        rep_r, rep_nxt;
  logic [SUM_W-1:0]  rsum_r, rsum_nxt;
  logic [11:0]       col_r, col_nxt;
  logic [15:0]       mean_r, mean_nxt;
  logic              fs_r, fs_nxt;
  logic [SUM_W-1:0]  tot_r, tot_nxt;
  logic              ov_r, ov_nxt;
  logic [11:0]       oc_r, oc_nxt;
  logic [1:0]        orep_r, orep_nxt;
  logic [15:0]       om_r, om_nxt, og_r, og_nxt;
  logic              ogv_r, ogv_nxt;
  logic [16:0]       rows, cols;
  logic [15:0]       share;
  logic [37:0]       grp_prod;

  always_comb begin
    rows = (rows_per_column == 13'd0) ? 17'd1 :
           (17'(rows_per_column) > 17'(MAX_ROWS)) ? 17'(MAX_ROWS) : 17'(rows_per_column);
    cols = (columns_per_frame == 13'd0) ? 17'd1 :
           (17'(columns_per_frame) > 17'(MAX_COLUMNS)) ? 17'(MAX_COLUMNS)
                                                      : 17'(columns_per_frame);
    share = (div_rsp.quot > DIV_W'(16'hFFFF)) ? 16'hFFFF : div_rsp.quot[15:0];
  end

  assign grp_prod = 38'(rsum_r) * 38'(GRP_RECIP);

  assign q_ready = (st_r == ST_IDLE) && !ov_r;

  always_comb begin
    st_nxt = st_r; row_nxt = row_r; acc_nxt = acc_r; rep_nxt = rep_r;
    rsum_nxt = rsum_r; col_nxt = col_r; mean_nxt = mean_r; fs_nxt = fs_r;
    tot_nxt = tot_r;
    ov_nxt = ov_r; oc_nxt = oc_r; orep_nxt = orep_r; om_nxt = om_r;
    og_nxt = og_r; ogv_nxt = ogv_r;
    div_req = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && q_ready) begin
          div_req.start = (q_data.total != '0);
          div_req.numer = {q_data.chosen, 16'd0};
          div_req.denom = DIV_W'(q_data.total);
          tot_nxt = q_data.total;
          fs_nxt  = q_data.frame_start;
          st_nxt  = ST_SHARE;
        end
      end
      ST_SHARE: begin
        if (tot_r == '0 || div_rsp.done) begin
          if (fs_r) begin
            row_nxt = '0; rep_nxt = '0; rsum_nxt = '0; col_nxt = '0;
            acc_nxt = (tot_r == '0) ? '0 : ACC_W'(share);
          end else begin
            acc_nxt = acc_r + ((tot_r == '0) ? '0 : ACC_W'(share));
          end
          if (17'(fs_r ? 12'd0 : row_r) + 17'd1 < rows) begin
            row_nxt = (fs_r ? 12'd0 : row_r) + 12'd1;
            st_nxt  = ST_IDLE;
          end else begin
            div_req.start = 1'b1;
            div_req.numer = DIV_W'(acc_nxt);
            div_req.denom = DIV_W'(rows);
            st_nxt = ST_MEAN;
          end
        end
      end
      ST_MEAN: begin
        if (div_rsp.done) begin
          mean_nxt = div_rsp.quot[15:0];
          rsum_nxt = rsum_r + SUM_W'(div_rsp.quot[15:0]);
          if (32'(rep_r) + 32'd1 >= 32'(REPLICATES)) begin
            st_nxt = ST_GROUP;
          end else begin
            og_nxt = '0; ogv_nxt = 1'b0;
            st_nxt = ST_EMIT;
          end
        end
      end
      ST_GROUP: begin
        og_nxt = grp_prod[GRP_SHIFT+15:GRP_SHIFT]; ogv_nxt = 1'b1;
        st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; oc_nxt = col_r; orep_nxt = rep_r; om_nxt = mean_r;
          row_nxt = '0; acc_nxt = '0;
          if (ogv_r) begin
            rsum_nxt = '0; rep_nxt = '0;
            col_nxt = (17'(col_r) + 17'd1 >= cols) ? 12'd0 : col_r + 12'd1;
          end else begin
            rep_nxt = rep_r + 2'd1;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; row_r <= '0; acc_r <= '0; rep_r <= '0;
      rsum_r <= '0; col_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; row_r <= row_nxt; acc_r <= acc_nxt; rep_r <= rep_nxt;
      rsum_r <= rsum_nxt; col_r <= col_nxt; ov_r <= ov_nxt;
    end
    mean_r <= mean_nxt; fs_r <= fs_nxt; tot_r <= tot_nxt;
    oc_r <= oc_nxt; orep_r <= orep_nxt; om_r <= om_nxt;
    og_r <= og_nxt; ogv_r <= ogv_nxt;
  end

  assign out_valid       = ov_r;
  assign column_index    = oc_r;
  assign replicate_index = orep_r;
  assign replicate_mean  = om_r;
  assign group_mean      = og_r;
  assign group_valid     = ogv_r;

endmodule

// ===== src/chromaticity_column_mean_core.sv =====
`timescale 1ns / 1ps
// Chromaticity column mean: per pixel, the selected channel's share of R+G+B
// as a Q0.16 fraction, averaged over a column's rows per replicate, plus the
// mean over replicates on the last one. A two-entry queue lets the front take
// pixels while the back end works. The back end runs a shared 32-step serial
// divider: a pixel with a nonzero sum occupies it for its share divide, one
// with a zero sum skips it. A column's last pixel adds the mean divide and
// the hand-off to the output register, the last replicate a group-mean step.
// No pixel enters the back end while a result waits on out_tready.
module chromaticity_column_mean_core #(
  parameter int unsigned REPLICATES  = 3
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // red_level, green_level, blue_level
  input  logic         in_tuser,   // frame_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // column_index, replicate_index, replicate_mean,
                                   // group_mean, group_valid, zero fill
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import ccm_pkg::*;

  logic [1:0]   chan_r;
  logic [12:0]  rows_r, cols_r;
  logic         q_valid, q_ready, wr;
  pix_t         q_data;
  div_req_t     div_req;
  div_rsp_t     div_rsp;
  logic [11:0]  column_index;
  logic [1:0]   replicate_index;
  logic [15:0]  replicate_mean, group_mean;
  logic         group_valid;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= CHAN_RED;
      rows_r <= 13'd4096;
      cols_r <= 13'd4096;
    end else if (wr) begin
      unique case (cfg_paddr[3:2])
        REG_CHANNEL: chan_r <= cfg_pwdata[1:0];
        REG_ROWS:    rows_r <= cfg_pwdata[12:0];
        REG_COLUMNS: cols_r <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_CHANNEL: cfg_prdata = {30'd0, chan_r};
      REG_ROWS:    cfg_prdata = {19'd0, rows_r};
      REG_COLUMNS: cfg_prdata = {19'd0, cols_r};
      default:     cfg_prdata = '0;
    endcase
  end

  ccm_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .red(in_tdata[15:0]), .green(in_tdata[31:16]), .blue(in_tdata[47:32]),
    .frame_start(in_tuser), .channel_select(chan_r),
    .q_valid, .q_ready, .q_data
  );

  ccm_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  ccm_back #(
    .REPLICATES(REPLICATES)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .rows_per_column(rows_r), .columns_per_frame(cols_r),
    .div_req, .div_rsp,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .column_index, .replicate_index, .replicate_mean, .group_mean, .group_valid
  );

  assign out_tdata = {1'b0, group_valid, group_mean, replicate_mean,
                      replicate_index, column_index};

endmodule

// ===== tb/tb_chromaticity_column_mean_core.sv =====
`timescale 1ns / 1ps
module tb_chromaticity_column_mean_core;
  import ccm_pkg::*;

  typedef struct packed {
    logic        group_valid;
    logic [15:0] group_mean;
    logic [15:0] replicate_mean;
    logic [1:0]  replicate_index;
    logic [11:0] column_index;
  } col_mean_t;

  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // red_level, green_level, blue_level
  logic        in_tuser;   // frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // column_index, replicate_index, replicate_mean,
                           // group_mean, group_valid, zero fill
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  chromaticity_column_mean_core u_dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor state
  logic [1:0]  chan_sel;
  logic [12:0] rows_reg;
  logic [12:0] cols_reg;
  int unsigned row_cnt;
  int unsigned share_acc;
  int unsigned rep_cnt;
  int unsigned rep_acc;
  int unsigned col_cnt;

  col_mean_t   pending_means[$];
  int          mismatches;
  int          results_seen;
  int          groups_seen;
  int          pixels_sent;
  int          idle_cycles;

  function automatic int unsigned pixel_share(logic [15:0] r, logic [15:0] g,
                                              logic [15:0] b);
    logic [17:0] total;
    logic [15:0] chosen;
    logic [33:0] q;
    total = 18'(r) + 18'(g) + 18'(b);
    case (chan_sel)
      CHAN_GREEN: chosen = g;
      CHAN_BLUE:  chosen = b;
      default:    chosen = r;
    endcase
    if (total == 0) return 0;
    q = {chosen, 16'd0} / total;
    return (q > 65535) ? 65535 : 32'(q);
  endfunction

  task automatic predict_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                               logic fs);
    int unsigned rows;
    int unsigned cols;
    int unsigned mean;
    col_mean_t   res;
    rows = (rows_reg == 0) ? 1 : (rows_reg > 4096) ? 4096 : rows_reg;
    cols = (cols_reg == 0) ? 1 : (cols_reg > 4096) ? 4096 : cols_reg;
    if (fs) begin
      row_cnt = 0; share_acc = 0; rep_cnt = 0; rep_acc = 0; col_cnt = 0;
    end
    share_acc += pixel_share(r, g, b);
    if (row_cnt + 1 < rows) begin
      row_cnt++;
      return;
    end
    mean = share_acc / rows;
    rep_acc += mean;
    res = '0;
    res.column_index = col_cnt[11:0];
    res.replicate_index = rep_cnt[1:0];
    res.replicate_mean = mean[15:0];
    if (rep_cnt + 1 >= 3) begin
      res.group_mean = 16'(rep_acc / 3);
      res.group_valid = 1'b1;
      rep_acc = 0;
      rep_cnt = 0;
      col_cnt = (col_cnt + 1 >= cols) ? 0 : col_cnt + 1;
    end else begin
      rep_cnt++;
    end
    row_cnt = 0;
    share_acc = 0;
    pending_means.insert(pending_means.size(), res);
  endtask

  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                            logic fs);
    // burst/gap pattern of the sender
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tdata <= {b, g, r};
    in_tuser <= fs;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(r, g, b, fs);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(negedge clk);
    // a pixel may still be in the divider without a result pending
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_CHANNEL: chan_sel = val[1:0];
      REG_ROWS:    rows_reg = val[12:0];
      REG_COLUMNS: cols_reg = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [1:0] ch, logic [31:0] rows, logic [31:0] cols);
    drain();
    write_reg(REG_CHANNEL, 32'(ch));
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLUMNS, cols);
  endtask

  task automatic send_random_pixel(logic fs);
    logic [15:0] r, g, b;
    case ($urandom_range(0, 5))
      0: begin r = '0; g = '0; b = '0; end
      1: begin r = 16'hFFFF; g = '0; b = '0; end
      2: begin
        r = 16'($urandom); g = 16'($urandom_range(0, 3)); b = 16'($urandom_range(0, 3));
      end
      default: begin r = 16'($urandom); g = 16'($urandom); b = 16'($urandom); end
    endcase
    send_pixel(r, g, b, fs);
  endtask

  task automatic test_extremes;
    configure(CHAN_RED, 1, 2);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(16'h0001, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(16'hAAAA, 16'h5555, 16'h0000, 1'b0);
    send_pixel(16'h5555, 16'hAAAA, 16'hFFFF, 1'b0);
    configure(CHAN_GREEN, 2, 1);
    repeat (6) send_random_pixel(1'b0);
    configure(CHAN_BLUE, 1, 4096);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    send_pixel(16'h1234, 16'h0000, 16'h0001, 1'b0);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
    // selector three falls back to red
    configure(2'd3, 3, 0);
    repeat (6) send_random_pixel(1'b0);
    // frame start mid-column
    send_random_pixel(1'b1);
    repeat (2) send_random_pixel(1'b0);
  endtask

  task automatic test_clamped_counts;
    configure(CHAN_GREEN, 0, 8191);
    repeat (6) send_random_pixel(1'b0);
    configure(CHAN_RED, 5000, 3);
    repeat (4) send_random_pixel(1'b0);
    // lower the count mid-column so the next pixel ends it
    configure(CHAN_RED, 2, 3);
    repeat (6) send_random_pixel(1'b0);
  endtask

  task automatic test_random_frames;
    int phase;
    int n;
    for (phase = 0; phase < 10; phase++) begin
      configure(2'($urandom_range(0, 3)), $urandom_range(1, 6), $urandom_range(1, 4));
      n = $urandom_range(35, 55);
      for (int i = 0; i < n; i++)
        send_random_pixel(($urandom_range(0, 40) == 0) || i == 0);
      if (phase == 4) drain();
    end
  endtask

  task automatic test_long_column;
    configure(CHAN_BLUE, 256, 1);
    for (int i = 0; i < 256; i++) send_random_pixel(i == 0);
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 15) < 11) || ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    col_mean_t got;
    col_mean_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[46:0];
      results_seen++;
      if (got.group_valid) groups_seen++;
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_means.pop_front();
        if (got !== want || out_tdata[47] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: col %0d/%0d rep %0d/%0d mean %0d/%0d group %0d/%0d v %0b/%0b",
                     want.column_index, got.column_index, want.replicate_index,
                     got.replicate_index, want.replicate_mean, got.replicate_mean,
                     want.group_mean, got.group_mean, want.group_valid, got.group_valid);
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    out_tready = 1'b0;
    idle_cycles = 0; mismatches = 0; results_seen = 0; groups_seen = 0;
    pixels_sent = 0;
    chan_sel = CHAN_RED; rows_reg = 13'd4096; cols_reg = 13'd4096;
    row_cnt = 0; share_acc = 0; rep_cnt = 0; rep_acc = 0; col_cnt = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_clamped_counts();
    test_random_frames();
    test_long_column();
    drain();
    if (pending_means.size() != 0) mismatches++;
    $display("Sent %0d pixels under all channel selects and clamped counts; checked %0d results",
             pixels_sent, results_seen);
    $display("including %0d group means; mismatches %0d", groups_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ccm_pkg.sv
src/ccm_front.sv
src/ccm_div.sv
src/ccm_back.sv
src/chromaticity_column_mean_core.sv
tb/tb_chromaticity_column_mean_core.sv
